### hw/rtl/crt_pkg.sv
// Shared types and constants for the call/return tracker.
// No dependencies; used by crt_stack_ram and call_return_tracker_unit.
package crt_pkg;

   localparam int ADDR_W  = 64;
   localparam int SIZE_W  = 16;
   localparam int TRANS_W = 3;
   localparam int DEPTH_W = 6;

   localparam logic [TRANS_W-1:0] TR_START      = 3'd0;
   localparam logic [TRANS_W-1:0] TR_SEQUENTIAL = 3'd1;
   localparam logic [TRANS_W-1:0] TR_CALL       = 3'd2;
   localparam logic [TRANS_W-1:0] TR_RETURN     = 3'd3;
   localparam logic [TRANS_W-1:0] TR_JUMP       = 3'd4;

   typedef struct packed {
      logic [ADDR_W-1:0] return_pc;
      logic [ADDR_W-1:0] caller_pc;
      logic [ADDR_W-1:0] symbol_pc;
   } entry_type;

endpackage

### hw/rtl/call_return_tracker_unit.sv
// Top level of the call/return tracker: sequencer, shadow stack scan, output register.
// Depends on crt_pkg and crt_stack_ram.
//
// Usage:
//   One request per executed code block on the req_ channel (valid/ready).
//   One response per request on the rsp_ channel: transition class, caller
//   address, current symbol, stack depth and overflow flag.
//   req_ready is high only while the sequencer is idle; one request is in
//   work at a time.
//   Start, sequential and call-by-symbol blocks, and any block while the
//   stack is empty, go from the classify state straight to the finish state.
//   Other blocks scan the stack from the top down with one compare per
//   cycle through the stack RAM's registered read port, until the first
//   matching return address or the bottom of the stack.
//   The response sits in an output register; a new request is accepted
//   while it waits. If rsp_ready stays low, the next request finishes its
//   work and then holds until the output register frees up.
//   Synchronous reset empties the stack and forgets the previous block;
//   no clearing pass is needed.
module call_return_tracker_unit #(
   parameter int STACK_DEPTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [crt_pkg::ADDR_W-1:0]    req_block_pc,
   input  logic [crt_pkg::SIZE_W-1:0]    req_block_size,
   input  logic                          req_symbol_entry,
   input  logic [crt_pkg::ADDR_W-1:0]    req_return_address,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [crt_pkg::TRANS_W-1:0]   rsp_transition,
   output logic                          rsp_caller_valid,
   output logic [crt_pkg::ADDR_W-1:0]    rsp_caller_block_pc,
   output logic [crt_pkg::ADDR_W-1:0]    rsp_symbol_pc,
   output logic [crt_pkg::DEPTH_W-1:0]   rsp_depth,
   output logic                          rsp_overflow
);

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);

   localparam logic [1:0] ST_IDLE     = 2'd0;
   localparam logic [1:0] ST_CLASSIFY = 2'd1;
   localparam logic [1:0] ST_SCAN     = 2'd2;
   localparam logic [1:0] ST_FINISH   = 2'd3;

   logic [1:0]                        state_ff, state_in;
   logic [crt_pkg::ADDR_W-1:0]        pc_ff, pc_in;
   logic [crt_pkg::SIZE_W-1:0]        size_ff, size_in;
   logic                              sym_ff, sym_in;
   logic [crt_pkg::ADDR_W-1:0]        ret_ff, ret_in;
   logic [crt_pkg::ADDR_W-1:0]        expected_ff, expected_in;
   logic                              have_prev_ff, have_prev_in;
   logic [crt_pkg::ADDR_W-1:0]        prev_pc_ff, prev_pc_in;
   logic [crt_pkg::SIZE_W-1:0]        prev_size_ff, prev_size_in;
   logic [crt_pkg::ADDR_W-1:0]        cur_sym_ff, cur_sym_in;
   logic [CW-1:0]                     count_ff, count_in;
   logic [crt_pkg::TRANS_W-1:0]       trans_ff, trans_in;
   logic [AW-1:0]                     scan_ptr_ff, scan_ptr_in;
   logic [AW-1:0]                     cmp_idx_ff, cmp_idx_in;
   logic                              cmp_valid_ff, cmp_valid_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [crt_pkg::TRANS_W-1:0]       rsp_trans_ff, rsp_trans_in;
   logic                              rsp_cvalid_ff, rsp_cvalid_in;
   logic [crt_pkg::ADDR_W-1:0]        rsp_caller_ff, rsp_caller_in;
   logic [crt_pkg::ADDR_W-1:0]        rsp_sym_ff, rsp_sym_in;
   logic [crt_pkg::DEPTH_W-1:0]       rsp_depth_ff, rsp_depth_in;
   logic                              rsp_ovf_ff, rsp_ovf_in;

   logic                              ram_wr_en;
   crt_pkg::entry_type                ram_wr_data;
   logic                              ram_rd_en;
   crt_pkg::entry_type                ram_rd_data;

   logic                              req_fire;
   logic                              slot_free;
   logic                              hit;
   logic                              last;
   logic                              room;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign hit  = cmp_valid_ff && (ram_rd_data.return_pc == pc_ff);
   assign last = cmp_valid_ff && (cmp_idx_ff == '0);
   assign room = (count_ff < CW'(STACK_DEPTH));

   assign ram_wr_data.return_pc = expected_ff;
   assign ram_wr_data.caller_pc = prev_pc_ff;
   assign ram_wr_data.symbol_pc = cur_sym_ff;

   crt_stack_ram #(
      .DEPTH(STACK_DEPTH),
      .AW   (AW)
   ) u_stack (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(count_ff[AW-1:0]),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(scan_ptr_ff),
      .rd_data(ram_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      pc_in         = pc_ff;
      size_in       = size_ff;
      sym_in        = sym_ff;
      ret_in        = ret_ff;
      expected_in   = expected_ff;
      have_prev_in  = have_prev_ff;
      prev_pc_in    = prev_pc_ff;
      prev_size_in  = prev_size_ff;
      cur_sym_in    = cur_sym_ff;
      count_in      = count_ff;
      trans_in      = trans_ff;
      scan_ptr_in   = scan_ptr_ff;
      cmp_idx_in    = cmp_idx_ff;
      cmp_valid_in  = cmp_valid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_trans_in  = rsp_trans_ff;
      rsp_cvalid_in = rsp_cvalid_ff;
      rsp_caller_in = rsp_caller_ff;
      rsp_sym_in    = rsp_sym_ff;
      rsp_depth_in  = rsp_depth_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               pc_in       = req_block_pc;
               size_in     = req_block_size;
               sym_in      = req_symbol_entry;
               ret_in      = req_return_address;
               expected_in = prev_pc_ff + crt_pkg::ADDR_W'(prev_size_ff);
               state_in    = ST_CLASSIFY;
            end
         end
         ST_CLASSIFY: begin
            cmp_valid_in = 1'b0;
            scan_ptr_in  = AW'(count_ff - CW'(1));
            state_in     = ST_FINISH;
            if (!have_prev_ff) begin
               trans_in = crt_pkg::TR_START;
            end else if (expected_ff == pc_ff) begin
               trans_in = crt_pkg::TR_SEQUENTIAL;
            end else if (sym_ff) begin
               trans_in = crt_pkg::TR_CALL;
            end else if (count_ff == '0) begin
               trans_in = (ret_ff == expected_ff) ? crt_pkg::TR_CALL : crt_pkg::TR_JUMP;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (hit) begin
               trans_in = crt_pkg::TR_RETURN;
               state_in = ST_FINISH;
            end else if (last) begin
               trans_in = (ret_ff == expected_ff) ? crt_pkg::TR_CALL : crt_pkg::TR_JUMP;
               state_in = ST_FINISH;
            end else begin
               ram_rd_en    = 1'b1;
               cmp_valid_in = 1'b1;
               cmp_idx_in   = scan_ptr_ff;
               scan_ptr_in  = scan_ptr_ff - AW'(1);
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_trans_in  = trans_ff;
               rsp_cvalid_in = 1'b0;
               rsp_caller_in = '0;
               rsp_ovf_in    = 1'b0;
               case (trans_ff)
                  crt_pkg::TR_START: begin
                     cur_sym_in = pc_ff;
                  end
                  crt_pkg::TR_CALL: begin
                     rsp_cvalid_in = 1'b1;
                     rsp_caller_in = prev_pc_ff;
                     cur_sym_in    = pc_ff;
                     if (room) begin
                        ram_wr_en = 1'b1;
                        count_in  = count_ff + CW'(1);
                     end else begin
                        rsp_ovf_in = 1'b1;
                     end
                  end
                  crt_pkg::TR_RETURN: begin
                     rsp_cvalid_in = 1'b1;
                     rsp_caller_in = ram_rd_data.caller_pc;
                     cur_sym_in    = ram_rd_data.symbol_pc;
                     count_in      = CW'(cmp_idx_ff);
                  end
                  default: begin
                  end
               endcase
               rsp_sym_in   = cur_sym_in;
               rsp_depth_in = crt_pkg::DEPTH_W'(count_in);
               have_prev_in = 1'b1;
               prev_pc_in   = pc_ff;
               prev_size_in = size_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         have_prev_ff <= 1'b0;
         prev_pc_ff   <= '0;
         prev_size_ff <= '0;
         cur_sym_ff   <= '0;
         count_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         have_prev_ff <= have_prev_in;
         prev_pc_ff   <= prev_pc_in;
         prev_size_ff <= prev_size_in;
         cur_sym_ff   <= cur_sym_in;
         count_ff     <= count_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pc_ff         <= pc_in;
      size_ff       <= size_in;
      sym_ff        <= sym_in;
      ret_ff        <= ret_in;
      expected_ff   <= expected_in;
      trans_ff      <= trans_in;
      scan_ptr_ff   <= scan_ptr_in;
      cmp_idx_ff    <= cmp_idx_in;
      rsp_trans_ff  <= rsp_trans_in;
      rsp_cvalid_ff <= rsp_cvalid_in;
      rsp_caller_ff <= rsp_caller_in;
      rsp_sym_ff    <= rsp_sym_in;
      rsp_depth_ff  <= rsp_depth_in;
      rsp_ovf_ff    <= rsp_ovf_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_transition      = rsp_trans_ff;
   assign rsp_caller_valid    = rsp_cvalid_ff;
   assign rsp_caller_block_pc = rsp_caller_ff;
   assign rsp_symbol_pc       = rsp_sym_ff;
   assign rsp_depth           = rsp_depth_ff;
   assign rsp_overflow        = rsp_ovf_ff;

endmodule

### hw/rtl/crt_stack_ram.sv
// Shadow stack storage: one write port, one registered read port.
// Depends on crt_pkg for the entry layout.
module crt_stack_ram #(
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  crt_pkg::entry_type  wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output crt_pkg::entry_type  rd_data
);

   crt_pkg::entry_type mem [DEPTH];
   crt_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### dv/tb_top.sv
// Self-checking testbench for call_return_tracker_unit: executed code blocks in, one
// transition response per block out, checked against a built-in shadow stack predictor.
// Depends on crt_pkg and the call_return_tracker_unit RTL.
module tb_top;

   localparam int STACK_DEPTH = 32;
   localparam int GEN = 0;
   localparam int CHK = 1;
   localparam int RANDOM_PER_PHASE = 333;
   localparam int DRAIN_CYCLES = 60;
   localparam int unsigned CYCLE_LIMIT = 600000;

   typedef struct packed {
      logic [crt_pkg::ADDR_W-1:0] pc;
      logic [crt_pkg::SIZE_W-1:0] size;
      logic                       sym;
      logic [crt_pkg::ADDR_W-1:0] ret_addr;
   } block_req_type;

   typedef struct packed {
      logic [crt_pkg::TRANS_W-1:0] transition;
      logic                        caller_valid;
      logic [crt_pkg::ADDR_W-1:0]  caller_pc;
      logic [crt_pkg::ADDR_W-1:0]  symbol_pc;
      logic [crt_pkg::DEPTH_W-1:0] depth;
      logic                        overflow;
   } track_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [crt_pkg::ADDR_W-1:0] req_block_pc = '0;
   logic [crt_pkg::SIZE_W-1:0] req_block_size = '0;
   logic req_symbol_entry = 1'b0;
   logic [crt_pkg::ADDR_W-1:0] req_return_address = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [crt_pkg::TRANS_W-1:0] rsp_transition;
   logic rsp_caller_valid;
   logic [crt_pkg::ADDR_W-1:0] rsp_caller_block_pc;
   logic [crt_pkg::ADDR_W-1:0] rsp_symbol_pc;
   logic [crt_pkg::DEPTH_W-1:0] rsp_depth;
   logic rsp_overflow;

   // two copies of the tracker state: one steers stimulus, one checks responses
   bit seen_prev [2];
   bit [crt_pkg::ADDR_W-1:0] prev_pc [2];
   bit [crt_pkg::SIZE_W-1:0] prev_size [2];
   bit [crt_pkg::ADDR_W-1:0] cur_sym [2];
   int unsigned stk_count [2];
   bit [crt_pkg::ADDR_W-1:0] stk_ret_pc [2][STACK_DEPTH];
   bit [crt_pkg::ADDR_W-1:0] stk_caller_pc [2][STACK_DEPTH];
   bit [crt_pkg::ADDR_W-1:0] stk_sym_pc [2][STACK_DEPTH];

   block_req_type block_queue [$];
   track_rsp_type rsp_due [$];
   block_req_type drv_block;
   bit req_taken = 1'b0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int errors = 0;
   int gen_count = 0;
   int unsigned cycle_count = 0;

   call_return_tracker_unit #(
      .STACK_DEPTH(STACK_DEPTH)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_block_pc(req_block_pc),
      .req_block_size(req_block_size),
      .req_symbol_entry(req_symbol_entry),
      .req_return_address(req_return_address),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_transition(rsp_transition),
      .rsp_caller_valid(rsp_caller_valid),
      .rsp_caller_block_pc(rsp_caller_block_pc),
      .rsp_symbol_pc(rsp_symbol_pc),
      .rsp_depth(rsp_depth),
      .rsp_overflow(rsp_overflow)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic track_rsp_type track_block(input int m, input block_req_type b);
      track_rsp_type r;
      logic [crt_pkg::ADDR_W-1:0] end_pc;
      int unsigned i;
      bit hit;
      bit is_call;
      r = '0;
      hit = 1'b0;
      is_call = 1'b0;
      if (!seen_prev[m]) begin
         r.transition = crt_pkg::TR_START;
         cur_sym[m] = b.pc;
      end else begin
         end_pc = prev_pc[m] + {{(crt_pkg::ADDR_W-crt_pkg::SIZE_W){1'b0}}, prev_size[m]};
         if (end_pc == b.pc) begin
            r.transition = crt_pkg::TR_SEQUENTIAL;
         end else if (b.sym) begin
            is_call = 1'b1;
            r.transition = crt_pkg::TR_CALL;
         end else begin
            r.transition = crt_pkg::TR_JUMP;
            i = stk_count[m];
            while (i > 0 && !hit) begin
               i = i - 1;
               if (stk_ret_pc[m][i] == b.pc) begin
                  hit = 1'b1;
                  r.transition = crt_pkg::TR_RETURN;
                  r.caller_valid = 1'b1;
                  r.caller_pc = stk_caller_pc[m][i];
                  cur_sym[m] = stk_sym_pc[m][i];
                  stk_count[m] = i;
               end
            end
            if (!hit && b.ret_addr == end_pc) begin
               is_call = 1'b1;
               r.transition = crt_pkg::TR_CALL;
            end
         end
         if (is_call) begin
            r.caller_valid = 1'b1;
            r.caller_pc = prev_pc[m];
            if (stk_count[m] < STACK_DEPTH) begin
               stk_ret_pc[m][stk_count[m]] = end_pc;
               stk_caller_pc[m][stk_count[m]] = prev_pc[m];
               stk_sym_pc[m][stk_count[m]] = cur_sym[m];
               stk_count[m] = stk_count[m] + 1;
            end else begin
               r.overflow = 1'b1;
            end
            cur_sym[m] = b.pc;
         end
      end
      seen_prev[m] = 1'b1;
      prev_pc[m] = b.pc;
      prev_size[m] = b.size;
      r.symbol_pc = cur_sym[m];
      r.depth = stk_count[m][crt_pkg::DEPTH_W-1:0];
      return r;
   endfunction

   function automatic logic [crt_pkg::ADDR_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [crt_pkg::ADDR_W-1:0] rand_addr();
      int unsigned k;
      k = $urandom_range(9);
      if (k < 6) return rand64();
      if (k < 8) return {44'd0, 20'($urandom)};
      return {48'hFFFF_FFFF_FFFF, 16'($urandom)};
   endfunction

   function automatic logic [crt_pkg::SIZE_W-1:0] rand_size();
      int unsigned k;
      k = $urandom_range(9);
      if (k == 0) return '0;
      if (k == 1) return '1;
      if (k < 6) return crt_pkg::SIZE_W'($urandom_range(64, 1));
      return crt_pkg::SIZE_W'($urandom);
   endfunction

   task automatic add_block(input logic [crt_pkg::ADDR_W-1:0] pc,
                            input logic [crt_pkg::SIZE_W-1:0] size,
                            input logic sym, input logic [crt_pkg::ADDR_W-1:0] ret_addr);
      block_req_type b;
      b = {pc, size, sym, ret_addr};
      void'(track_block(GEN, b));
      block_queue.insert(block_queue.size(), b);
      gen_count++;
   endtask

   task automatic add_random_block();
      logic [crt_pkg::ADDR_W-1:0] end_pc;
      logic [crt_pkg::ADDR_W-1:0] pc;
      logic [crt_pkg::SIZE_W-1:0] size;
      logic sym;
      logic [crt_pkg::ADDR_W-1:0] ret_addr;
      int unsigned k;
      int unsigned j;
      int unsigned depth;
      int unsigned burst;
      end_pc = prev_pc[GEN] + {{(crt_pkg::ADDR_W-crt_pkg::SIZE_W){1'b0}}, prev_size[GEN]};
      depth = stk_count[GEN];
      pc = rand_addr();
      size = rand_size();
      sym = 1'b0;
      ret_addr = rand64();
      k = $urandom_range(99);
      // keep the stack from pinning at full most of the time
      if (depth > 20 && k >= 20 && k < 47 && $urandom_range(1) == 1) k = 50;
      j = 0;
      if (depth > 0) j = ($urandom_range(9) < 7) ? depth - 1 : $urandom_range(depth - 1);
      if ($urandom_range(99) < 2) begin
         // deep call chain, usually runs into a full stack
         burst = $urandom_range(40, 12);
         repeat (burst) add_block(rand_addr(), rand_size(), 1'b1, rand64());
         return;
      end
      if (k < 20) begin
         pc = end_pc;
      end else if (k < 35) begin
         sym = 1'b1;
      end else if (k < 47) begin
         ret_addr = end_pc;
      end else if (k < 70 && depth > 0) begin
         pc = stk_ret_pc[GEN][j];
      end else if (k < 74 && depth > 0) begin
         pc = stk_ret_pc[GEN][j];
         sym = 1'b1;
      end else if (k < 80 && depth > 0) begin
         pc = stk_caller_pc[GEN][j];
         size = crt_pkg::SIZE_W'(stk_ret_pc[GEN][j] - stk_caller_pc[GEN][j]);
      end else if (k < 90) begin
         pc = rand64();
         size = crt_pkg::SIZE_W'($urandom);
         sym = 1'($urandom_range(1));
      end
      add_block(pc, size, sym, ret_addr);
   endtask

   task automatic add_directed_blocks();
      add_block(64'hFFFF_FFFF_FFFF_FFF0, 16'h0020, 1'b0, 64'h0);
      add_block(64'h10, 16'h0040, 1'b0, 64'h0);
      add_block(64'h1000, 16'h0100, 1'b1, 64'h0);
      add_block(64'h2000, 16'h0010, 1'b0, 64'h1100);
      add_block(64'h1100, 16'h0008, 1'b0, 64'h0);
      add_block(64'hDEAD_0000, 16'hFFFF, 1'b0, 64'h0);
      add_block(64'h50, 16'h0020, 1'b1, 64'h0);
      add_block(64'h10, 16'h0040, 1'b0, 64'h0);
      add_block(64'h3000, 16'h0004, 1'b1, 64'h0);
      add_block(64'h50, 16'h0004, 1'b0, 64'h0);
      add_block(64'h50, 16'h0004, 1'b0, 64'h0);
      add_block(64'h0, 16'h0000, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
      add_block(64'h0, 16'hFFFF, 1'b0, 64'h0);
      add_block(64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
      add_block(64'hFFFE, 16'hFFFF, 1'b0, 64'h0);
      add_block(64'hFFFF, 16'h0001, 1'b0, 64'h0);
      add_block(64'h5555_AAAA_5555_AAAA, 16'hA5A5, 1'b0, 64'h0);
      add_block(64'hAAAA_5555_AAAA_5555, 16'h5A5A, 1'b0, 64'h5555_AAAA_5556_5054);
      add_block(64'h7000, 16'h0010, 1'b0, 64'h0);
   endtask

   task automatic check_field(input string name, input logic [crt_pkg::ADDR_W-1:0] want,
                              input logic [crt_pkg::ADDR_W-1:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
      end
   endtask

   // request driver, inputs change on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (block_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            drv_block = block_queue.pop_front();
            req_valid <= 1'b1;
            req_block_pc <= drv_block.pc;
            req_block_size <= drv_block.size;
            req_symbol_entry <= drv_block.sym;
            req_return_address <= drv_block.ret_addr;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_ready <= !reset && ($urandom_range(99) >= recv_stall_pct);
   end

   // monitor and scoreboard, sampled on the rising edge
   always @(posedge clock) begin
      track_rsp_type want;
      block_req_type seen;
      cycle_count++;
      req_taken = 1'b0;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (rsp_due.size() == 0) begin
               errors++;
               $display("%0t unexpected response: expected none actual transition %0d pc %0h",
                        $time, rsp_transition, rsp_caller_block_pc);
            end else begin
               want = rsp_due.pop_front();
               check_field("transition", want.transition, rsp_transition);
               check_field("caller_valid", want.caller_valid, rsp_caller_valid);
               check_field("caller_block_pc", want.caller_pc, rsp_caller_block_pc);
               check_field("symbol_pc", want.symbol_pc, rsp_symbol_pc);
               check_field("depth", want.depth, rsp_depth);
               check_field("overflow", want.overflow, rsp_overflow);
            end
         end
         if (req_valid && req_ready) begin
            req_taken = 1'b1;
            seen = {req_block_pc, req_block_size, req_symbol_entry, req_return_address};
            rsp_due.insert(rsp_due.size(), track_block(CHK, seen));
         end
      end
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      int base;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      add_directed_blocks();
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
            default: begin send_idle_pct = 23; recv_stall_pct = 23; end
         endcase
         base = gen_count;
         while (gen_count - base < RANDOM_PER_PHASE) add_random_block();
         while (block_queue.size() != 0) @(posedge clock);
      end
      while (req_valid || rsp_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && rsp_due.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
